@@ hw/rtl/pdp_pkg.sv @@
// Shared types, constants and element helpers for the packed dot-product unit.
package pdp_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_LANES  = 8;
    localparam int OP_W       = 17;
    localparam int PROD_W     = 2 * OP_W;
    localparam int PIPE_DEPTH = 5;
    localparam int LANE_IDX_W = 3;

    typedef enum logic [2:0] {
        ACT_DOT2_S16 = 3'd0,
        ACT_DOT2_U16 = 3'd1,
        ACT_DOT4_S8  = 3'd2,
        ACT_DOT4_U8  = 3'd3,
        ACT_DOT8_S4  = 3'd4,
        ACT_DOT8_U4  = 3'd5
    } pdp_action_t;

    typedef enum logic [1:0] {
        WID_NONE,
        WID_16,
        WID_8,
        WID_4
    } pdp_width_t;

    typedef struct packed {
        logic mul_en;
        logic sat_en;
    } pdp_lane_ctl_t;

    typedef struct packed {
        logic pair_en;
        logic quad_en;
        logic sum_en;
    } pdp_merge_ctl_t;

    function automatic pdp_width_t width_of(input logic [2:0] action);
        pdp_width_t wid;
        case (action)
            ACT_DOT2_S16, ACT_DOT2_U16: wid = WID_16;
            ACT_DOT4_S8,  ACT_DOT4_U8:  wid = WID_8;
            ACT_DOT8_S4,  ACT_DOT8_U4:  wid = WID_4;
            default:                    wid = WID_NONE;
        endcase
        return wid;
    endfunction

    function automatic logic is_signed_fmt(input logic [2:0] action);
        return (action == ACT_DOT2_S16) || (action == ACT_DOT4_S8) ||
               (action == ACT_DOT8_S4);
    endfunction

    // Pick element idx of the given format, extended to OP_W bits.
    // Elements past the end of the format read as zero.
    function automatic logic signed [OP_W-1:0] elem_of(
        input logic [WORD_W-1:0]     word,
        input logic [2:0]            action,
        input logic [LANE_IDX_W-1:0] idx
    );
        logic [WORD_W-1:0]     sh;
        logic                  ext;
        logic signed [OP_W-1:0] val;
        sh  = '0;
        ext = 1'b0;
        val = '0;
        case (width_of(action))
            WID_16:
            begin
                if (idx < 3'd2)
                begin
                    sh  = word >> {idx[0], 4'b0000};
                    ext = is_signed_fmt(action) & sh[15];
                    val = {ext, sh[15:0]};
                end
            end
            WID_8:
            begin
                if (idx < 3'd4)
                begin
                    sh  = word >> {idx[1:0], 3'b000};
                    ext = is_signed_fmt(action) & sh[7];
                    val = {{(OP_W-8){ext}}, sh[7:0]};
                end
            end
            WID_4:
            begin
                sh  = word >> {idx, 2'b00};
                ext = is_signed_fmt(action) & sh[3];
                val = {{(OP_W-4){ext}}, sh[3:0]};
            end
            default:
            begin
                val = '0;
            end
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/pdp_lane.sv @@
// One multiply lane: element product, then optional saturation to the element range.
module pdp_lane (
    input  logic                               clk,
    input  pdp_pkg::pdp_lane_ctl_t             ctl,
    input  logic signed [pdp_pkg::OP_W-1:0]    elem_a,
    input  logic signed [pdp_pkg::OP_W-1:0]    elem_b,
    input  pdp_pkg::pdp_width_t                width,
    input  logic                               sgn,
    input  logic                               clamp,
    output logic [pdp_pkg::WORD_W-1:0]         product
);

    logic signed [pdp_pkg::PROD_W-1:0] prod_reg;
    pdp_pkg::pdp_width_t               wid_reg;
    logic                              sgn_reg;
    logic                              clamp_reg;
    logic [pdp_pkg::WORD_W-1:0]        out_reg;

    logic signed [pdp_pkg::PROD_W-1:0] hi;
    logic signed [pdp_pkg::PROD_W-1:0] lo;
    logic signed [pdp_pkg::PROD_W-1:0] sat;
    logic signed [pdp_pkg::PROD_W-1:0] one;
    logic [4:0]                        bits;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg  <= elem_a * elem_b;
            wid_reg   <= width;
            sgn_reg   <= sgn;
            clamp_reg <= clamp;
        end
    end

    always_comb
    begin
        one = pdp_pkg::PROD_W'(1);
        case (wid_reg)
            pdp_pkg::WID_16: bits = 5'd16;
            pdp_pkg::WID_8:  bits = 5'd8;
            default:         bits = 5'd4;
        endcase
        if (sgn_reg)
        begin
            hi = (one <<< (bits - 5'd1)) - one;
            lo = -(one <<< (bits - 5'd1));
        end
        else
        begin
            hi = (one <<< bits) - one;
            lo = '0;
        end
        sat = prod_reg;
        if (clamp_reg)
        begin
            if (prod_reg > hi)
            begin
                sat = hi;
            end
            else if (prod_reg < lo)
            begin
                sat = lo;
            end
        end
    end

    // Keep the low word: wrapping sum downstream.
    always_ff @(posedge clk)
    begin
        if (ctl.sat_en)
        begin
            out_reg <= sat[pdp_pkg::WORD_W-1:0];
        end
    end

    assign product = out_reg;

endmodule

@@ hw/rtl/pdp_merge.sv @@
// Registered adder tree that folds the lane products and the addend into one word.
module pdp_merge (
    input  logic                                                  clk,
    input  pdp_pkg::pdp_merge_ctl_t                               ctl,
    input  logic [pdp_pkg::NUM_LANES-1:0][pdp_pkg::WORD_W-1:0]    products,
    input  logic [pdp_pkg::WORD_W-1:0]                            addend,
    output logic [pdp_pkg::WORD_W-1:0]                            result
);

    localparam int NUM_PAIRS = pdp_pkg::NUM_LANES / 2;

    logic [NUM_PAIRS-1:0][pdp_pkg::WORD_W-1:0] pair_reg;
    logic [pdp_pkg::WORD_W-1:0]                add_reg;
    logic [pdp_pkg::WORD_W-1:0]                quad0_reg;
    logic [pdp_pkg::WORD_W-1:0]                quad1_reg;
    logic [pdp_pkg::WORD_W-1:0]                sum_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.pair_en)
        begin
            for (int j = 0; j < NUM_PAIRS; j++)
            begin
                pair_reg[j] <= products[2*j] + products[2*j+1];
            end
            add_reg <= addend;
        end
    end

    // Fold the addend into the second quad.
    always_ff @(posedge clk)
    begin
        if (ctl.quad_en)
        begin
            quad0_reg <= pair_reg[0] + pair_reg[1];
            quad1_reg <= pair_reg[2] + pair_reg[3] + add_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            sum_reg <= quad0_reg + quad1_reg;
        end
    end

    assign result = sum_reg;

endmodule

@@ hw/rtl/packed_integer_dot_product_top.sv @@
// Packed integer dot product: eight multiply lanes feeding a registered adder tree.
// Stages in order from input transfer to result valid: multiply, saturate, pair add,
//   quad add with addend, final add into the output register.
// Throughput: one item per cycle; each pipeline stage advances independently, so
//   bubbles are squeezed out and a stalled result only blocks once the pipe is full.
// Reset: rst_n clears the stage valid bits only; datapath registers are not reset.
module packed_integer_dot_product_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  action,
    input  logic [pdp_pkg::WORD_W-1:0]  src_a,
    input  logic [pdp_pkg::WORD_W-1:0]  src_b,
    input  logic [pdp_pkg::WORD_W-1:0]  addend,
    input  logic                        clamp_enable,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pdp_pkg::WORD_W-1:0]  result
);

    localparam int LAST = pdp_pkg::PIPE_DEPTH - 1;

    // Stage occupancy and per-stage advance enables.
    logic [pdp_pkg::PIPE_DEPTH-1:0] v_reg;
    logic [pdp_pkg::PIPE_DEPTH-1:0] v_next;
    logic [pdp_pkg::PIPE_DEPTH-1:0] en;

    pdp_pkg::pdp_lane_ctl_t  lane_ctl;
    pdp_pkg::pdp_merge_ctl_t merge_ctl;

    // Addend travels alongside the lane stages until the tree picks it up.
    logic [pdp_pkg::WORD_W-1:0] add0_reg;
    logic [pdp_pkg::WORD_W-1:0] add1_reg;

    logic [pdp_pkg::NUM_LANES-1:0][pdp_pkg::WORD_W-1:0] lane_prod;

    pdp_pkg::pdp_width_t in_width;
    logic                in_sgn;

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb
    begin
        en[LAST] = !v_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < pdp_pkg::PIPE_DEPTH; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[LAST];

    assign lane_ctl.mul_en    = en[0];
    assign lane_ctl.sat_en    = en[1];
    assign merge_ctl.pair_en  = en[2];
    assign merge_ctl.quad_en  = en[3];
    assign merge_ctl.sum_en   = en[4];

    // Hold the addend in step with the multiply and saturate stages.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            add0_reg <= addend;
        end
        if (en[1])
        begin
            add1_reg <= add0_reg;
        end
    end

    // Format decode; unused action codes give zero elements, so the result is the addend.
    assign in_width = pdp_pkg::width_of(action);
    assign in_sgn   = pdp_pkg::is_signed_fmt(action);

    for (genvar i = 0; i < pdp_pkg::NUM_LANES; i++)
    begin : g_lane
        pdp_lane u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .elem_a  (pdp_pkg::elem_of(src_a, action, pdp_pkg::LANE_IDX_W'(i))),
            .elem_b  (pdp_pkg::elem_of(src_b, action, pdp_pkg::LANE_IDX_W'(i))),
            .width   (in_width),
            .sgn     (in_sgn),
            .clamp   (clamp_enable),
            .product (lane_prod[i])
        );
    end

    pdp_merge u_merge (
        .clk      (clk),
        .ctl      (merge_ctl),
        .products (lane_prod),
        .addend   (add1_reg),
        .result   (result)
    );

    // An empty output register never blocks the input side.
    a_idle_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register is empty");

    // A result transfer frees the whole chain for a new input.
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> in_ready)
        else $error("input stalled during a result transfer");

    // Items in flight grow by exactly one on an input-only transfer.
    a_count_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready))
        |=> ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("accepted item lost or duplicated in the pipeline");

    // Items in flight drop by exactly one on an output-only transfer.
    a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && out_valid && out_ready)
        |=> ($countones(v_reg) + 1 == $past($countones(v_reg))))
        else $error("delivered item not retired from the pipeline");

endmodule
